// ===== rtl/ticsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ticsm_pkg: shared constants and types of the two-index color scatter map
// Map geometry, field widths, action codes and the structs passed between
// the register block, the index scaler and the map controller.
// ----------------------------------------------------------------------------
package ticsm_pkg;

	localparam int MAP_WIDTH  = 256;
	localparam int MAP_HEIGHT = 256;

	localparam int COL_W     = $clog2(MAP_WIDTH);
	localparam int ROW_W     = $clog2(MAP_HEIGHT);
	localparam int QUOT_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int IDX_W     = 16;
	localparam int NUM_W     = IDX_W + QUOT_W;
	localparam int CH_W      = 8;
	localparam int COLOR_W   = 3 * CH_W;
	localparam int POS_W     = 8;
	localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int ADDR_W    = $clog2(MAP_DEPTH);

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_PLOT  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	localparam int          APB_ADDR_W  = 3;
	localparam logic        REG_SCALE_1 = 1'b0;
	localparam logic        REG_SCALE_2 = 1'b1;
	localparam logic [15:0] SCALE_RESET = 16'hFFFF;

	typedef struct packed {
		logic [IDX_W-1:0] scale_first;
		logic [IDX_W-1:0] scale_second;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [IDX_W-1:0] index_first;
		logic [IDX_W-1:0] index_second;
		logic [CH_W-1:0]  pixel_red;
		logic [CH_W-1:0]  pixel_green;
		logic [CH_W-1:0]  pixel_blue;
		logic [POS_W-1:0] read_column;
		logic [POS_W-1:0] read_row;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] map_column;
		logic [POS_W-1:0] map_row;
		logic [CH_W-1:0]  entry_red;
		logic [CH_W-1:0]  entry_green;
		logic [CH_W-1:0]  entry_blue;
		logic             range_error;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] index_first;
		logic [IDX_W-1:0] index_second;
		logic [IDX_W-1:0] scale_first;
		logic [IDX_W-1:0] scale_second;
	} scale_req_t;

	typedef struct packed {
		logic             done;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} scale_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/two_index_color_scatter_map_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_index_color_scatter_map_unit: two-index color scatter map
// Plots pixel colors into a map addressed by two scaled indices, clears the
// map and reads entries back, one result per input item.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ stream; s_tuser carries the action (clear, plot,
// read, no operation) and s_tdata the indices, color and read position.
// Every accepted item yields exactly one result transfer on the m_ stream,
// with the range flag on m_tuser. The APB port sets the two full-scale
// registers and must only be written while no item is in flight.
// Items are handled one at a time. A plot runs a multiply, then one quotient
// bit per cycle in two parallel restoring dividers, one per index, and
// then writes the entry. A read goes through the registered map memory;
// a rejected or no-operation item goes straight to its result. In each
// case the result is loaded into the output register as the sequencer
// returns to idle. A clear sweeps the memory one entry per cycle over all
// MAP_WIDTH*MAP_HEIGHT (65536) entries. After reset the same sweep runs
// once and s_tready stays low meanwhile; configuration writes are taken
// during it. Results sit in an output register, so the next item is
// accepted while a result waits; if the receiver stalls, the following
// result holds the sequencer until the register drains.
// ----------------------------------------------------------------------------
module two_index_color_scatter_map_unit
	import ticsm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// index_first[15:0], index_second[31:16], pixel_red[39:32],
	// pixel_green[47:40], pixel_blue[55:48], read_column[63:56], read_row[71:64]
	input  wire logic [71:0]           s_tdata,
	// action[1:0]
	input  wire logic [1:0]            s_tuser,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// map_column[7:0], map_row[15:8], entry_red[23:16], entry_green[31:24],
	// entry_blue[39:32]
	output logic      [39:0]           m_tdata,
	// range_error[0]
	output logic      [0:0]            m_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	cfg_t       cfg;
	item_t      item;
	result_t    result;
	scale_req_t scale_req;
	scale_rsp_t scale_rsp;

	// Unpack the input transfer into its fields.
	assign item.action       = s_tuser;
	assign item.index_first  = s_tdata[15:0];
	assign item.index_second = s_tdata[31:16];
	assign item.pixel_red    = s_tdata[39:32];
	assign item.pixel_green  = s_tdata[47:40];
	assign item.pixel_blue   = s_tdata[55:48];
	assign item.read_column  = s_tdata[63:56];
	assign item.read_row     = s_tdata[71:64];

	// Pack the result transfer.
	assign m_tdata = {result.entry_blue, result.entry_green, result.entry_red,
	                  result.map_row, result.map_column};
	assign m_tuser = result.range_error;

	ticsm_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ticsm_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scale_req),
		.rsp    (scale_rsp)
	);

	ticsm_map_ctrl u_map_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item         (item),
		.item_valid   (s_tvalid),
		.item_ready   (s_tready),
		.scale_req    (scale_req),
		.scale_rsp    (scale_rsp),
		.result       (result),
		.result_valid (m_tvalid),
		.result_ready (m_tready)
	);

endmodule
`default_nettype wire

// ===== rtl/ticsm_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ticsm_cfg_regs: configuration registers
// Holds the two full-scale registers behind a simple APB slave.
// ----------------------------------------------------------------------------
module ticsm_cfg_regs
	import ticsm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Register select uses the word index only; the byte offset is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_first  <= SCALE_RESET;
			cfg_q.scale_second <= SCALE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_SCALE_1: cfg_q.scale_first  <= pwdata[IDX_W-1:0];
				REG_SCALE_2: cfg_q.scale_second <= pwdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SCALE_1: prdata = 32'(cfg_q.scale_first);
			REG_SCALE_2: prdata = 32'(cfg_q.scale_second);
			default:     prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/ticsm_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ticsm_scaler: index to map position scaler
// Multiplies both indices by the last column and row number, then divides
// each by its full scale with two parallel restoring dividers, one bit a cycle.
// ----------------------------------------------------------------------------
module ticsm_scaler
	import ticsm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  scale_req_t      req,
	output scale_rsp_t      rsp
);

	localparam int CNT_W = $clog2(QUOT_W + 1);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOAD = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;
	localparam logic [1:0] PH_FIN  = 2'd3;

	logic [1:0]        phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  prod_a_q, prod_b_q;
	logic [IDX_W-1:0]  div_a_q, div_b_q;
	logic [IDX_W-1:0]  rem_a_q, rem_b_q;
	logic [QUOT_W-1:0] low_a_q, low_b_q;
	logic [QUOT_W-1:0] quot_a_q, quot_b_q;

	logic [IDX_W:0]    trial_a, trial_b;
	logic              take_a, take_b;

	assign trial_a = {rem_a_q, low_a_q[QUOT_W-1]};
	assign trial_b = {rem_b_q, low_b_q[QUOT_W-1]};
	assign take_a  = trial_a >= {1'b0, div_a_q};
	assign take_b  = trial_b >= {1'b0, div_b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: if (req.start) phase_q <= PH_LOAD;
				PH_LOAD: begin
					phase_q <= PH_DIV;
					cnt_q   <= '0;
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUOT_W - 1)) phase_q <= PH_FIN;
				end
				PH_FIN:  phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				prod_a_q <= NUM_W'(req.index_first) * NUM_W'(MAP_WIDTH - 1);
				prod_b_q <= NUM_W'(req.index_second) * NUM_W'(MAP_HEIGHT - 1);
				div_a_q  <= req.scale_first;
				div_b_q  <= req.scale_second;
			end
			PH_LOAD: begin
				// The index never exceeds its scale, so the top part is below it.
				rem_a_q <= prod_a_q[NUM_W-1:QUOT_W];
				rem_b_q <= prod_b_q[NUM_W-1:QUOT_W];
				low_a_q <= prod_a_q[QUOT_W-1:0];
				low_b_q <= prod_b_q[QUOT_W-1:0];
			end
			PH_DIV: begin
				rem_a_q  <= take_a ? IDX_W'(trial_a - {1'b0, div_a_q}) : trial_a[IDX_W-1:0];
				rem_b_q  <= take_b ? IDX_W'(trial_b - {1'b0, div_b_q}) : trial_b[IDX_W-1:0];
				low_a_q  <= low_a_q << 1;
				low_b_q  <= low_b_q << 1;
				quot_a_q <= QUOT_W'({quot_a_q, take_a});
				quot_b_q <= QUOT_W'({quot_b_q, take_b});
			end
			default: ;
		endcase
	end

	assign rsp.done   = (phase_q == PH_FIN);
	assign rsp.column = quot_a_q[COL_W-1:0];
	assign rsp.row    = quot_b_q[ROW_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/ticsm_map_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ticsm_map_ctrl: map memory and item sequencer
// Owns the color map memory, decodes each item, runs clear sweeps, plots
// and reads, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ticsm_map_ctrl
	import ticsm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	input  item_t      item,
	input  wire logic  item_valid,
	output logic       item_ready,
	output scale_req_t scale_req,
	input  scale_rsp_t scale_rsp,
	output result_t    result,
	output logic       result_valid,
	input  wire logic  result_ready
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_RDREQ = 3'd4;
	localparam logic [2:0] ST_RDCAP = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [COLOR_W-1:0] map_mem [MAP_DEPTH];
	logic [COLOR_W-1:0] rd_data_q;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  sweep_q;
	logic               clr_item_q;
	logic               out_valid_q;

	logic [COL_W-1:0]   pos_col_q;
	logic [ROW_W-1:0]   pos_row_q;
	logic [COLOR_W-1:0] color_q;
	result_t            res_q;
	result_t            out_q;
	result_t            acc_res;

	logic [IDX_W-1:0]   s1_eff, s2_eff;
	logic               accept, out_free, load_out, plot_err, read_err, sweep_end;
	logic [ADDR_W-1:0]  entry_addr, wr_addr;
	logic               wr_en;
	logic [COLOR_W-1:0] wr_data;

	// A zero full scale behaves as a scale of one.
	assign s1_eff = (cfg.scale_first  == '0) ? IDX_W'(1) : cfg.scale_first;
	assign s2_eff = (cfg.scale_second == '0) ? IDX_W'(1) : cfg.scale_second;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !out_valid_q || result_ready;
	assign load_out   = (state_q == ST_DONE) && out_free;
	assign plot_err   = (item.index_first > s1_eff) || (item.index_second > s2_eff);
	assign read_err   = (32'(item.read_column) >= MAP_WIDTH) ||
	                    (32'(item.read_row) >= MAP_HEIGHT);
	assign sweep_end  = (sweep_q == ADDR_W'(MAP_DEPTH - 1));

	assign entry_addr = ADDR_W'(ADDR_W'(pos_row_q) * ADDR_W'(MAP_WIDTH) + ADDR_W'(pos_col_q));
	assign wr_en      = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign wr_addr    = (state_q == ST_CLEAR) ? sweep_q : entry_addr;
	assign wr_data    = (state_q == ST_CLEAR) ? '0 : color_q;

	assign scale_req.start        = accept && (item.action == ACT_PLOT) && !plot_err;
	assign scale_req.index_first  = item.index_first;
	assign scale_req.index_second = item.index_second;
	assign scale_req.scale_first  = s1_eff;
	assign scale_req.scale_second = s2_eff;

	// Result fields known at acceptance; the rest are filled in later.
	always_comb begin
		acc_res = '0;
		case (item.action)
			ACT_PLOT: acc_res.range_error = plot_err;
			ACT_READ: begin
				acc_res.map_column  = item.read_column;
				acc_res.map_row     = item.read_row;
				acc_res.range_error = read_err;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) map_mem[wr_addr] <= wr_data;
		rd_data_q <= map_mem[entry_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			clr_item_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					if (sweep_end) begin
						sweep_q <= '0;
						state_q <= clr_item_q ? ST_DONE : ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (item.action)
							ACT_CLEAR: begin
								clr_item_q <= 1'b1;
								sweep_q    <= '0;
								state_q    <= ST_CLEAR;
							end
							ACT_PLOT: state_q <= plot_err ? ST_DONE : ST_SCALE;
							ACT_READ: state_q <= read_err ? ST_DONE : ST_RDREQ;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCALE: if (scale_rsp.done) state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_DONE;
				ST_RDREQ: state_q <= ST_RDCAP;
				ST_RDCAP: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						clr_item_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q     <= acc_res;
			color_q   <= {item.pixel_red, item.pixel_green, item.pixel_blue};
			pos_col_q <= COL_W'(item.read_column);
			pos_row_q <= ROW_W'(item.read_row);
		end else if ((state_q == ST_SCALE) && scale_rsp.done) begin
			pos_col_q <= scale_rsp.column;
			pos_row_q <= scale_rsp.row;
			res_q     <= {POS_W'(scale_rsp.column), POS_W'(scale_rsp.row), color_q, 1'b0};
		end else if (state_q == ST_RDCAP) begin
			res_q <= {res_q.map_column, res_q.map_row, rd_data_q, res_q.range_error};
		end else if (state_q == ST_CLEAR) begin
			res_q <= '0;
		end
		if (load_out) out_q <= res_q;
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== bench/two_index_color_scatter_map_unit_test.sv =====
// ----------------------------------------------------------------------------
// two_index_color_scatter_map_unit_test: self-checking bench for the map unit
// Streams clear, plot, read and no-operation items into the unit under
// several full-scale settings and checks every result against a shadow copy
// of the color map kept inside the bench.
// ----------------------------------------------------------------------------
module two_index_color_scatter_map_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ticsm_pkg::*;

	// Receiver stall styles, chosen per phase.
	localparam int READY_ALWAYS   = 0;
	localparam int READY_RANDOM   = 1;
	localparam int READY_PERIODIC = 2;

	// The long receiver hold-off starts after this many result transfers and
	// lasts this many cycles. It lands in the first random phase.
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_CYCLES = 600;

	// Number of random items per random phase.
	localparam int PHASE_ITEMS = 205;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic [71:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [31:0]           pwdata  = '0;
	logic [31:0]           prdata;
	logic                  pready;

	two_index_color_scatter_map_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Bench state: the shadow map, the bench's copy of the two full-scale
	// registers, the feed of items waiting to be offered and the results
	// still owed by the unit.
	// ------------------------------------------------------------------
	logic [COLOR_W-1:0] shadow_colors [MAP_DEPTH] = '{default: '0};
	logic [IDX_W-1:0]   full_scale_1 = SCALE_RESET;
	logic [IDX_W-1:0]   full_scale_2 = SCALE_RESET;

	item_t   item_feed[$];
	result_t expected_map_results[$];

	int unsigned items_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count  = 0;

	// Pacing knobs that the stimulus process sets per phase.
	int unsigned gap_limit   = 0;
	int          ready_style = READY_ALWAYS;

	// Driver-private state.
	item_t       offered;
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	// Receiver-private state.
	int unsigned drained_count = 0;
	int unsigned hold_left     = 0;
	bit          hold_done     = 1'b0;
	logic [7:0]  ready_tick    = '0;

	// Monitor-private state.
	result_t seen;
	result_t want;

	// One line per mismatch, and the count goes up.
	task automatic flag_mismatch(input string note);
		$display("[%0t] %s", $time, note);
		mismatch_count++;
	endtask

	// Predicts the result of one item and updates the shadow map. Indices are
	// scaled with exact integer floors; a full scale of zero behaves as one.
	function automatic result_t map_response(input item_t it);
		result_t     r;
		logic [31:0] eff_1;
		logic [31:0] eff_2;
		logic [31:0] col;
		logic [31:0] row;
		int unsigned slot;
		r = '0;
		eff_1 = (full_scale_1 == '0) ? 32'd1 : {16'd0, full_scale_1};
		eff_2 = (full_scale_2 == '0) ? 32'd1 : {16'd0, full_scale_2};
		case (it.action)
			ACT_CLEAR: begin
				foreach (shadow_colors[k])
					shadow_colors[k] = '0;
			end
			ACT_PLOT: begin
				if ({16'd0, it.index_first} > eff_1 || {16'd0, it.index_second} > eff_2) begin
					// Out of range: nothing is written and only the flag is set.
					r.range_error = 1'b1;
				end else begin
					col = ({16'd0, it.index_first} * 32'(MAP_WIDTH - 1)) / eff_1;
					row = ({16'd0, it.index_second} * 32'(MAP_HEIGHT - 1)) / eff_2;
					slot = row * MAP_WIDTH + col;
					shadow_colors[slot] = {it.pixel_red, it.pixel_green, it.pixel_blue};
					r.map_column = col[POS_W-1:0];
					r.map_row    = row[POS_W-1:0];
					{r.entry_red, r.entry_green, r.entry_blue} = shadow_colors[slot];
				end
			end
			ACT_READ: begin
				r.map_column = it.read_column;
				r.map_row    = it.read_row;
				if (it.read_column >= MAP_WIDTH || it.read_row >= MAP_HEIGHT) begin
					r.range_error = 1'b1;
				end else begin
					slot = it.read_row * MAP_WIDTH + it.read_column;
					{r.entry_red, r.entry_green, r.entry_blue} = shadow_colors[slot];
				end
			end
			default: begin
				// No operation: every field stays zero.
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers items from the feed in bursts with random gaps. A
	// transfer that completes is handed to the predictor at that same edge,
	// so expectations line up with the order the unit accepted the items.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_map_results.push_back(map_response(offered));
			// While an offer is still waiting it must be held unchanged.
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (item_feed.size() > 0) begin
					offered = item_feed.pop_front();
					s_tdata <= {offered.read_row, offered.read_column, offered.pixel_blue,
						offered.pixel_green, offered.pixel_red, offered.index_second,
						offered.index_first};
					s_tuser  <= offered.action;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left   = $urandom_range(0, gap_limit);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: decides m_tready for the next cycle. Once, after a fixed
	// number of result transfers, it holds off for a long stretch so that
	// the unit's output register fills and the input side stalls.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				drained_count++;
			ready_tick++;
			if (!hold_done && drained_count == HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (ready_style)
					READY_ALWAYS:   m_tready <= 1'b1;
					READY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
					default:        m_tready <= (ready_tick[2:0] < 3'd5);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every result transfer is compared field by field with the
	// oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.map_column  = m_tdata[7:0];
			seen.map_row     = m_tdata[15:8];
			seen.entry_red   = m_tdata[23:16];
			seen.entry_green = m_tdata[31:24];
			seen.entry_blue  = m_tdata[39:32];
			seen.range_error = m_tuser[0];
			if (expected_map_results.size() == 0) begin
				flag_mismatch($sformatf("result col %0d row %0d arrived with nothing owed",
					seen.map_column, seen.map_row));
			end else begin
				want = expected_map_results.pop_front();
				if (seen.map_column !== want.map_column)
					flag_mismatch($sformatf("result %0d map_column got %0d want %0d",
						results_checked, seen.map_column, want.map_column));
				if (seen.map_row !== want.map_row)
					flag_mismatch($sformatf("result %0d map_row got %0d want %0d",
						results_checked, seen.map_row, want.map_row));
				if (seen.entry_red !== want.entry_red)
					flag_mismatch($sformatf("result %0d entry_red got %0h want %0h",
						results_checked, seen.entry_red, want.entry_red));
				if (seen.entry_green !== want.entry_green)
					flag_mismatch($sformatf("result %0d entry_green got %0h want %0h",
						results_checked, seen.entry_green, want.entry_green));
				if (seen.entry_blue !== want.entry_blue)
					flag_mismatch($sformatf("result %0d entry_blue got %0h want %0h",
						results_checked, seen.entry_blue, want.entry_blue));
				if (seen.range_error !== want.range_error)
					flag_mismatch($sformatf("result %0d range_error got %0b want %0b",
						results_checked, seen.range_error, want.range_error));
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	function automatic item_t make_item(input logic [1:0] action, input logic [15:0] idx_1,
		input logic [15:0] idx_2, input logic [23:0] color, input logic [7:0] col,
		input logic [7:0] row);
		item_t it;
		it.action       = action;
		it.index_first  = idx_1;
		it.index_second = idx_2;
		{it.pixel_red, it.pixel_green, it.pixel_blue} = color;
		it.read_column  = col;
		it.read_row     = row;
		return it;
	endfunction

	task automatic queue_item(input item_t it);
		item_feed.push_back(it);
		items_sent++;
	endtask

	// A register write is a setup phase followed by an access phase; the
	// register takes the value at the edge where the access completes.
	task automatic write_scale(input logic reg_sel, input logic [IDX_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_SCALE_1)
			full_scale_1 = value;
		else
			full_scale_2 = value;
	endtask

	// Waits until every item handed out has produced its checked result,
	// then keeps waiting so that the unit's sequencer is surely back at rest.
	task automatic wait_drained();
		while (results_checked != items_sent)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Index bound: indices up to it land within the first nine columns or rows.
	function automatic logic [15:0] focus_limit(input logic [IDX_W-1:0] scale);
		logic [31:0] eff;
		eff = (scale == '0) ? 32'd1 : {16'd0, scale};
		return 16'((8 * eff) / 255);
	endfunction

	// An index at, just below or just above the full scale, or zero.
	function automatic logic [15:0] edge_index(input logic [IDX_W-1:0] scale);
		logic [16:0] eff;
		eff = (scale == '0) ? 17'd1 : {1'b0, scale};
		case ($urandom_range(0, 3))
			0:       return 16'd0;
			1:       return eff[15:0];
			2:       return (eff == 17'hFFFF) ? 16'hFFFF : 16'(eff + 1);
			default: return 16'(eff - 1);
		endcase
	endfunction

	// Most random items are plots and reads crowded into a small corner of
	// the map, so that writes collide and reads find written entries. The
	// rest spread over the whole index range, sit right at the full-scale
	// boundaries, or are no-operation items.
	function automatic item_t compose_random_item();
		item_t       it;
		int unsigned pick;
		it.action       = ACT_PLOT;
		it.index_first  = 16'($urandom);
		it.index_second = 16'($urandom);
		it.pixel_red    = 8'($urandom);
		it.pixel_green  = 8'($urandom);
		it.pixel_blue   = 8'($urandom);
		it.read_column  = 8'($urandom);
		it.read_row     = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			it.action = ACT_NOP;
		end else if (pick < 44) begin
			it.index_first  = 16'($urandom_range(0, focus_limit(full_scale_1)));
			it.index_second = 16'($urandom_range(0, focus_limit(full_scale_2)));
		end else if (pick < 56) begin
			// Full-range indices, already drawn above.
		end else if (pick < 64) begin
			it.index_first  = edge_index(full_scale_1);
			it.index_second = edge_index(full_scale_2);
		end else if (pick < 92) begin
			it.action      = ACT_READ;
			it.read_column = 8'($urandom_range(0, 7));
			it.read_row    = 8'($urandom_range(0, 7));
		end else begin
			it.action = ACT_READ;
		end
		return it;
	endfunction

	task automatic run_random_phase(input logic [IDX_W-1:0] scale_1,
		input logic [IDX_W-1:0] scale_2, input int unsigned gaps, input int style,
		input bit with_clear);
		int unsigned clear_at;
		write_scale(REG_SCALE_1, scale_1);
		write_scale(REG_SCALE_2, scale_2);
		gap_limit   = gaps;
		ready_style = style;
		clear_at    = $urandom_range(PHASE_ITEMS / 4, PHASE_ITEMS - PHASE_ITEMS / 4);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			// A clear sweeps the whole map and is slow, so at most one per phase.
			if (with_clear && n == clear_at)
				queue_item(make_item(ACT_CLEAR, 16'($urandom), 16'($urandom),
					24'($urandom), 8'($urandom), 8'($urandom)));
			queue_item(compose_random_item());
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Stimulus: reset, three directed phases, then random phases over a
	// spread of full-scale settings and pacing styles.
	// ------------------------------------------------------------------
	initial begin
		item_t quiet_item;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset scales: corners, a mid-map plot, overwrite of an entry,
		// a no-operation item with every field set, then a clear.
		gap_limit   = 2;
		ready_style = READY_RANDOM;
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'd255, 8'd255));
		queue_item(make_item(ACT_PLOT, 16'd0, 16'd0, 24'hFF00FF, 8'd0, 8'd0));
		queue_item(make_item(ACT_PLOT, 16'hFFFF, 16'hFFFF, 24'h00FF00, 8'd255, 8'd255));
		queue_item(make_item(ACT_PLOT, 16'd32768, 16'd257, 24'h123456, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd255, 8'd255));
		queue_item(make_item(ACT_PLOT, 16'd0, 16'd0, 24'hAA5501, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd0, 8'd0));
		quiet_item = '1;
		quiet_item.action = ACT_NOP;
		queue_item(quiet_item);
		queue_item(make_item(ACT_CLEAR, 16'd0, 16'd0, 24'h000000, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd255, 8'd255));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd127, 8'd1));
		wait_drained();

		// Small full scales: indices at, below and above the boundary.
		write_scale(REG_SCALE_1, 16'd1000);
		write_scale(REG_SCALE_2, 16'd1);
		queue_item(make_item(ACT_PLOT, 16'd1000, 16'd1, 24'hC3A5E7, 8'd0, 8'd0));
		queue_item(make_item(ACT_PLOT, 16'd1001, 16'd0, 24'h111111, 8'd0, 8'd0));
		queue_item(make_item(ACT_PLOT, 16'd0, 16'd2, 24'h222222, 8'd0, 8'd0));
		queue_item(make_item(ACT_PLOT, 16'd999, 16'd0, 24'h3C5A7E, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd254, 8'd0));
		wait_drained();

		// Zero full scales act as one: only indices zero and one are in range.
		write_scale(REG_SCALE_1, 16'd0);
		write_scale(REG_SCALE_2, 16'd0);
		queue_item(make_item(ACT_PLOT, 16'd0, 16'd0, 24'h0F1E2D, 8'd0, 8'd0));
		queue_item(make_item(ACT_PLOT, 16'd1, 16'd0, 24'h444444, 8'd0, 8'd0));
		queue_item(make_item(ACT_PLOT, 16'd0, 16'd1, 24'h555555, 8'd0, 8'd0));
		queue_item(make_item(ACT_READ, 16'd0, 16'd0, 24'h000000, 8'd0, 8'd0));
		wait_drained();

		run_random_phase(16'hFFFF, 16'hFFFF, 6, READY_RANDOM, 1'b1);
		run_random_phase(16'd1, 16'hFFFF, 0, READY_ALWAYS, 1'b0);
		run_random_phase(16'hFFFF, 16'd1, 3, READY_PERIODIC, 1'b1);
		run_random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 10,
			READY_RANDOM, 1'b0);
		run_random_phase(16'd255, 16'd255, 0, READY_PERIODIC, 1'b0);
		run_random_phase(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)), 4,
			READY_RANDOM, 1'b1);
		// Last phase runs with no idling on either side.
		run_random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 0,
			READY_ALWAYS, 1'b0);

		repeat (40) @(posedge clk);
		if (expected_map_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_map_results.size()));
		if (mismatch_count == 0) begin
			$display("two_index_color_scatter_map_unit: match");
		end else begin
			$display("two_index_color_scatter_map_unit: mismatch");
		end
		$finish;
	end

	// Watchdog: most of the simulated time of a correct run goes to
	// the map sweeps after reset and on each clear.
	initial begin
		#50_000_000;
		$display("two_index_color_scatter_map_unit: mismatch");
		$finish;
	end

endmodule
